// ===== src/lrs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the LPC residual synthesis block.
// No dependencies; every other file uses this package.
package lrs_pkg;

  // Filter geometry
  localparam int MaxOrder  = 16;
  localparam int NumBanks  = 4;
  localparam int CoefW     = 16;
  localparam int ResW      = 16;
  localparam int SampW     = 17;
  localparam int ProdW     = CoefW + SampW;
  localparam int AccW      = 38;
  localparam int FracBits  = 12;
  localparam int OrdW      = 5;
  localparam int TapIdxW   = 4;

  // Configuration port
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [ResW-1:0]  res_t;
  typedef logic signed [SampW-1:0] sample_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic [OrdW-1:0]         order_t;
  typedef logic [CfgIdxW-1:0]      cfg_idx_t;
  typedef logic [CfgDataW-1:0]     cfg_data_t;
  typedef logic [TapIdxW-1:0]      tap_idx_t;

  // Register indexes
  localparam cfg_idx_t RegOrder     = 3'd0;
  localparam cfg_idx_t RegCoefBank0 = 3'd1;
  localparam cfg_idx_t RegCoefBank1 = 3'd2;
  localparam cfg_idx_t RegCoefBank2 = 3'd3;
  localparam cfg_idx_t RegCoefBank3 = 3'd4;

  // Rounding and clipping of the prediction
  localparam acc_t RoundAdd = 38'sd2048;
  localparam acc_t SatHi    = 38'sd32767;
  localparam acc_t SatLo    = -38'sd32768;

  // Tap lane controls from the sequencer
  typedef struct packed {
    logic load;     // clear partial sum, capture coefficient
    logic sweep;    // rebuild step from the stored history
    logic advance;  // a word was accepted: shift the transposed chain
  } lane_ctl_t;

  // Round half up at bit 12, floor shift, clip to signed 16 bits
  function automatic res_t round_clip(acc_t a);
    acc_t r;
    acc_t q;
    r = a + RoundAdd;
    q = r >>> FracBits;
    if (q > SatHi) begin
      q = SatHi;
    end else if (q < SatLo) begin
      q = SatLo;
    end
    return res_t'(q[ResW-1:0]);
  endfunction

endpackage

// ===== src/lrs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for residual input and sample output words.
// Depends on lrs_pkg for the payload types.
interface lrs_in_if;
  logic             valid;
  logic             ready;
  lrs_pkg::res_t    residual;
  logic             block_end;

  modport source (output valid, output residual, output block_end, input ready);
  modport sink   (input valid, input residual, input block_end, output ready);
endinterface

interface lrs_out_if;
  logic              valid;
  logic              ready;
  lrs_pkg::sample_t  sample;
  logic              sample_last;

  modport source (output valid, output sample, output sample_last, input ready);
  modport sink   (input valid, input sample, input sample_last, output ready);
endinterface

// ===== src/lrs_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers: predictor order and four coefficient banks.
// Produces the coefficient set masked to the active order. Uses lrs_pkg.
module lrs_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  lrs_pkg::cfg_idx_t   cfg_index,
  input  lrs_pkg::cfg_data_t  cfg_wdata,
  output lrs_pkg::coef_t      eff_coef [lrs_pkg::MaxOrder]
);
  import lrs_pkg::*;

  order_t    order;
  cfg_data_t bank [NumBanks];
  order_t    taps;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      order <= order_t'(1);
      for (int b = 0; b < NumBanks; b++) begin
        bank[b] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        RegOrder:     order   <= cfg_wdata[OrdW-1:0];
        RegCoefBank0: bank[0] <= cfg_wdata;
        RegCoefBank1: bank[1] <= cfg_wdata;
        RegCoefBank2: bank[2] <= cfg_wdata;
        RegCoefBank3: bank[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Active tap count: zero counts as one, large values saturate
  always_comb begin
    if (order == '0) begin
      taps = order_t'(1);
    end else if (order > order_t'(MaxOrder)) begin
      taps = order_t'(MaxOrder);
    end else begin
      taps = order;
    end
  end

  // Unpack coefficients, zero the taps above the order
  always_comb begin
    for (int j = 0; j < MaxOrder; j++) begin
      if (order_t'(j) < taps) begin
        eff_coef[j] = coef_t'(bank[j >> 2][CoefW*(j & 3) +: CoefW]);
      end else begin
        eff_coef[j] = '0;
      end
    end
  end

endmodule

// ===== src/lrs_tap_lane.sv =====
`timescale 1ns / 1ps
// One tap of the transposed all-pole filter: a multiplier and a partial sum.
// Also rebuilds its partial sum from the history after a coefficient change.
module lrs_tap_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  lrs_pkg::lane_ctl_t   ctl,
  input  lrs_pkg::coef_t       coef_eff,
  input  lrs_pkg::sample_t     hist_new,
  input  lrs_pkg::sample_t     hist_tap,
  input  lrs_pkg::acc_t        w_up,
  input  lrs_pkg::coef_t       cs_up,
  output lrs_pkg::acc_t        w,
  output lrs_pkg::coef_t       cs
);
  import lrs_pkg::*;

  coef_t   mul_c;
  sample_t mul_s;
  prod_t   prod;

  // Shared multiplier: streaming uses the newest sample, rebuild walks history
  always_comb begin
    mul_c = ctl.sweep ? cs : coef_eff;
    mul_s = ctl.sweep ? hist_tap : hist_new;
    prod  = mul_c * mul_s;
  end

  // Partial sum register
  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else if (ctl.load) begin
      w <= '0;
    end else if (ctl.sweep) begin
      w <= w + acc_t'(prod);
    end else if (ctl.advance) begin
      w <= acc_t'(prod) + w_up;
    end
  end

  // Coefficient shift line used during rebuild
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cs <= coef_eff;
    end else if (ctl.sweep) begin
      cs <= cs_up;
    end
  end

endmodule

// ===== src/lrs_sweep_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: streaming, or rebuilding the partial sums after a register write.
// Drives the lane controls and the history tap index. Uses lrs_pkg.
module lrs_sweep_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 advance,
  output lrs_pkg::lane_ctl_t   ctl,
  output lrs_pkg::tap_idx_t    tap_idx,
  output logic                 run
);
  import lrs_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_LOAD  = 3'b010,
    ST_SWEEP = 3'b100
  } seq_state_t;

  seq_state_t state;
  seq_state_t state_next;
  tap_idx_t   cnt;

  // Next state; a register write always restarts the rebuild
  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = ST_LOAD;
    end else begin
      case (state)
        ST_RUN:   state_next = ST_RUN;
        ST_LOAD:  state_next = ST_SWEEP;
        ST_SWEEP: state_next = (cnt == '1) ? ST_RUN : ST_SWEEP;
        default:  state_next = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        cnt <= tap_idx_t'(1);
      end else if (state == ST_SWEEP) begin
        cnt <= cnt + tap_idx_t'(1);
      end
    end
  end

  // Lane controls
  always_comb begin
    ctl.load    = (state == ST_LOAD);
    ctl.sweep   = (state == ST_SWEEP);
    ctl.advance = advance;
    run         = (state == ST_RUN);
    tap_idx     = cnt;
  end

endmodule

// ===== src/lpc_residual_synthesis.sv =====
`timescale 1ns / 1ps
// LPC residual synthesis, transposed all-pole filter with up to 16 taps.
// Latency: the sample word is valid the cycle after its residual is taken.
// Throughput: one word per cycle unless the output stalls; the loop is one tap
// multiply plus round, clip and residual add. After the last register write the
// input stalls while the tap lanes rebuild their sums from the history.
// Reset (synchronous): history and partial sums zero, order 1, coefficients 0.
module lpc_residual_synthesis (
  input  logic                clk,
  input  logic                rst,
  lrs_in_if.sink              rx,
  lrs_out_if.source           tx,
  input  logic                cfg_we,
  input  lrs_pkg::cfg_idx_t   cfg_index,
  input  lrs_pkg::cfg_data_t  cfg_wdata
);
  import lrs_pkg::*;

  coef_t     eff_coef [MaxOrder];
  lane_ctl_t ctl;
  tap_idx_t  tap_idx;
  logic      run;
  logic      accept;

  sample_t   hist [MaxOrder];
  acc_t      w_chain [1:MaxOrder];
  coef_t     cs_chain [1:MaxOrder];

  prod_t     prod0;
  acc_t      pred_sum;
  res_t      pred;
  sample_t   samp_new;

  logic      out_valid;
  sample_t   sample_q;
  logic      last_q;

  lrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .eff_coef  (eff_coef)
  );

  lrs_sweep_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .advance (accept),
    .ctl     (ctl),
    .tap_idx (tap_idx),
    .run     (run)
  );

  // Tap lanes 1..15; lane 0 is folded into the output path
  assign w_chain[MaxOrder]  = '0;
  assign cs_chain[MaxOrder] = '0;

  for (genvar g = 1; g < MaxOrder; g++) begin : g_lane
    lrs_tap_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .coef_eff (eff_coef[g]),
      .hist_new (hist[0]),
      .hist_tap (hist[tap_idx]),
      .w_up     (w_chain[g+1]),
      .cs_up    (cs_chain[g+1]),
      .w        (w_chain[g]),
      .cs       (cs_chain[g])
    );
  end

  // Handshake: take a word while running, whenever the output register is free or draining
  assign rx.ready = run && (!out_valid || tx.ready);
  assign accept   = rx.valid && rx.ready;

  // Prediction from the newest sample and the chain, then reconstruction
  always_comb begin
    prod0    = eff_coef[0] * hist[0];
    pred_sum = acc_t'(prod0) + w_chain[1];
    pred     = round_clip(pred_sum);
    samp_new = sample_t'(rx.residual) + sample_t'(pred);
  end

  // Sample history, newest at entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MaxOrder; k++) begin
        hist[k] <= '0;
      end
    end else if (accept) begin
      hist[0] <= samp_new;
      for (int k = 1; k < MaxOrder; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= samp_new;
      last_q   <= rx.block_end;
    end
  end

  assign tx.valid       = out_valid;
  assign tx.sample      = sample_q;
  assign tx.sample_last = last_q;

endmodule
